>>> hdl/rqs_pkg.sv
// ----------------------------------------------------------------------------
// Ready queue scheduler package
// Policy and request codes, controller state encoding and the control
// bundle that the queue controller drives into every slot cell.
// ----------------------------------------------------------------------------
package rqs_pkg;

	// Scheduling policies held in the mode register.
	localparam logic [2:0] POL_FCFS = 3'd0;
	localparam logic [2:0] POL_LCFS = 3'd1;
	localparam logic [2:0] POL_SJF  = 3'd2;
	localparam logic [2:0] POL_RR   = 3'd3;
	localparam logic [2:0] POL_PRIO = 3'd4;

	// Request kinds.
	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_TAKE    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_FINISH = 3'b100
	} rqs_state_t;

	// Per-cell control: load the incoming entry, shift down from the upper
	// neighbor, plus the policy context that the cell's compare needs.
	typedef struct packed {
		logic       ins_here;
		logic       shift_here;
		logic [2:0] policy;
		logic       act_epoch;
		logic       ins_epoch;
	} cell_ctrl_t;

endpackage

>>> hdl/rqs_cell.sv
// ----------------------------------------------------------------------------
// Ready queue slot cell
// Holds one queue entry, shifts down from its upper neighbor on removal,
// and refines the running candidate that travels up the chain.
// ----------------------------------------------------------------------------
module rqs_cell
	import rqs_pkg::*;
#(
	parameter int ID_BITS   = 10,
	parameter int TIME_BITS = 16,
	parameter int IDX_BITS  = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [IDX_BITS-1:0]  my_idx,
	input  logic [ID_BITS-1:0]   ins_id,
	input  logic [TIME_BITS-1:0] ins_rem,
	input  logic [1:0]           ins_lvl,
	input  logic                 nb_valid,
	input  logic [ID_BITS-1:0]   nb_id,
	input  logic [TIME_BITS-1:0] nb_rem,
	input  logic [1:0]           nb_lvl,
	input  logic                 nb_epoch,
	output logic                 slot_valid,
	output logic [ID_BITS-1:0]   slot_id,
	output logic [TIME_BITS-1:0] slot_rem,
	output logic [1:0]           slot_lvl,
	output logic                 slot_epoch,
	input  logic [1+IDX_BITS+ID_BITS+TIME_BITS+2-1:0] cand_a_in,
	input  logic [1+IDX_BITS+ID_BITS+TIME_BITS+2-1:0] cand_b_in,
	output logic [1+IDX_BITS+ID_BITS+TIME_BITS+2-1:0] cand_a_out,
	output logic [1+IDX_BITS+ID_BITS+TIME_BITS+2-1:0] cand_b_out
);

	localparam int CAND_W  = 1 + IDX_BITS + ID_BITS + TIME_BITS + 2;
	localparam int REM_LO  = 2;
	localparam int ID_LO   = REM_LO + TIME_BITS;

	logic                 valid_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [1:0]           lvl_q;
	logic                 epoch_q;
	logic [CAND_W-1:0]    cand_a_q;
	logic [CAND_W-1:0]    cand_b_q;
	logic                 is_prio;
	logic                 elig_a;
	logic                 elig_b;
	logic                 better_a;
	logic                 better_b;
	logic [CAND_W-1:0]    own_cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins_here) begin
			valid_q <= 1'b1;
		end else if (ctrl.shift_here) begin
			valid_q <= nb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins_here) begin
			id_q    <= ins_id;
			rem_q   <= ins_rem;
			lvl_q   <= ins_lvl;
			epoch_q <= ctrl.ins_epoch;
		end else if (ctrl.shift_here) begin
			id_q    <= nb_id;
			rem_q   <= nb_rem;
			lvl_q   <= nb_lvl;
			epoch_q <= nb_epoch;
		end
	end

	// Under the priority policy, stream A collects active entries and
	// stream B expired ones; otherwise every valid entry goes to A.
	always_comb begin
		is_prio  = (ctrl.policy == POL_PRIO);
		elig_a   = valid_q && (!is_prio || (epoch_q == ctrl.act_epoch));
		elig_b   = valid_q && is_prio && (epoch_q != ctrl.act_epoch);
		own_cand = {1'b1, my_idx, id_q, rem_q, lvl_q};
		case (ctrl.policy)
			POL_LCFS: better_a = 1'b1;
			POL_SJF:  better_a = !cand_a_in[CAND_W-1] ||
				(rem_q < cand_a_in[ID_LO-1:REM_LO]);
			POL_PRIO: better_a = !cand_a_in[CAND_W-1] || (lvl_q > cand_a_in[1:0]);
			default:  better_a = !cand_a_in[CAND_W-1];
		endcase
		better_b = !cand_b_in[CAND_W-1] || (lvl_q > cand_b_in[1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_a_q <= '0;
			cand_b_q <= '0;
		end else begin
			cand_a_q <= (elig_a && better_a) ? own_cand : cand_a_in;
			cand_b_q <= (elig_b && better_b) ? own_cand : cand_b_in;
		end
	end

	assign slot_valid = valid_q;
	assign slot_id    = id_q;
	assign slot_rem   = rem_q;
	assign slot_lvl   = lvl_q;
	assign slot_epoch = epoch_q;
	assign cand_a_out = cand_a_q;
	assign cand_b_out = cand_b_q;

endmodule

>>> hdl/ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Ready queue scheduler
// A row of slot cells that keeps process entries in insertion order and
// picks the next one under FCFS, LCFS, SJF, round robin or priority levels
// with active and expired sets.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  request   in         req_valid / req_stall  kind, process_id,
//                                              remaining_time, priority_level
//  response  out        rsp_valid / rsp_stall  success, taken_id,
//                                              taken_remaining, taken_level
//  config    in         cfg_write_en           cfg_write_data (policy mode)
//
//  An insert item, and any item that is not a take, is answered at the edge
//  that accepts it. A take item first sweeps the chain: the candidate
//  travels through one cell per cycle, then the final step delivers the
//  result and shifts the younger entries down. Reset empties the queue,
//  selects FCFS and makes epoch 0 the active set. A stalled response
//  holds the controller in its final step and keeps new items out.
//
module ready_queue_scheduler
	import rqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 10,
	parameter int TIME_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration
	input  logic                 cfg_write_en,
	input  logic [2:0]           cfg_write_data,
	// Request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           kind,
	input  logic [ID_BITS-1:0]   process_id,
	input  logic [TIME_BITS-1:0] remaining_time,
	input  logic [1:0]           priority_level,
	// Response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 success,
	output logic [ID_BITS-1:0]   taken_id,
	output logic [TIME_BITS-1:0] taken_remaining,
	output logic [1:0]           taken_level
);

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CAND_W = 1 + IDX_W + ID_BITS + TIME_BITS + 2;
	localparam int REM_LO = 2;
	localparam int ID_LO  = REM_LO + TIME_BITS;
	localparam int IDX_LO = ID_LO + ID_BITS;

	rqs_state_t           state_q;
	logic [2:0]           policy_q;
	logic                 act_epoch_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     sweep_q;

	logic                 rsp_valid_q;
	logic                 success_q;
	logic [ID_BITS-1:0]   taken_id_q;
	logic [TIME_BITS-1:0] taken_rem_q;
	logic [1:0]           taken_lvl_q;

	logic                 out_free;
	logic                 req_fire;
	logic                 is_prio;
	logic                 ins_ok;
	logic                 ins_fire;
	logic                 finish_fire;
	logic                 rsp_load;
	logic                 a_found;
	logic                 b_found;
	logic                 use_b;
	logic                 take_ok;
	logic                 rem_fire;
	logic                 flip_epoch;
	logic [CAND_W-1:0]    pick;
	logic [IDX_W-1:0]     pick_idx;

	cell_ctrl_t           cell_ctrl [QUEUE_DEPTH];
	logic                 valid_vec [QUEUE_DEPTH+1];
	logic [ID_BITS-1:0]   id_vec    [QUEUE_DEPTH+1];
	logic [TIME_BITS-1:0] rem_vec   [QUEUE_DEPTH+1];
	logic [1:0]           lvl_vec   [QUEUE_DEPTH+1];
	logic                 epoch_vec [QUEUE_DEPTH+1];
	logic [CAND_W-1:0]    cand_a    [QUEUE_DEPTH+1];
	logic [CAND_W-1:0]    cand_b    [QUEUE_DEPTH+1];
	logic [QUEUE_DEPTH-1:0] valid_bits;

	// ------------------------------------------------------------------
	// Handshake. The response register is free when it is empty or being
	// taken in this cycle; only then can a new result be written.
	// ------------------------------------------------------------------
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign req_fire  = req_valid && !req_stall;
	assign is_prio   = (policy_q == POL_PRIO);

	// An expired-set insert only counts under the priority policy, and a
	// full queue turns every insert away.
	assign ins_ok = ((kind == KIND_INSERT) || ((kind == KIND_EXPIRED) && is_prio)) &&
		(count_q != CNT_W'(QUEUE_DEPTH));
	assign ins_fire = req_fire && ins_ok;

	// ------------------------------------------------------------------
	// Result of a take. The chain ends hold the winner among active entries
	// (or all entries outside the priority policy) and the winner among
	// expired ones. Under the priority policy, with no active entry left, the
	// sets swap, which happens even when the queue is empty.
	// ------------------------------------------------------------------
	assign finish_fire = (state_q == ST_FINISH) && out_free;
	assign a_found     = cand_a[QUEUE_DEPTH][CAND_W-1];
	assign b_found     = cand_b[QUEUE_DEPTH][CAND_W-1];
	assign use_b       = is_prio && !a_found && b_found;
	assign take_ok     = a_found || use_b;
	assign pick        = use_b ? cand_b[QUEUE_DEPTH] : cand_a[QUEUE_DEPTH];
	assign pick_idx    = pick[IDX_LO+IDX_W-1:IDX_LO];
	assign rem_fire    = finish_fire && take_ok;
	assign flip_epoch  = finish_fire && is_prio && !a_found;

	// A new result is written either for an item that is not a take, at
	// the edge that accepts it, or at the final step of a take.
	assign rsp_load = (req_fire && (kind != KIND_TAKE)) || finish_fire;

	// ------------------------------------------------------------------
	// Controller
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			policy_q    <= POL_FCFS;
			act_epoch_q <= 1'b0;
			count_q     <= '0;
			sweep_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				policy_q <= cfg_write_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (kind == KIND_TAKE) begin
							state_q <= ST_SEARCH;
							sweep_q <= '0;
						end else if (ins_ok) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SEARCH: begin
					// The candidate moves up one cell per cycle until it reaches the end.
					if (sweep_q == IDX_W'(QUEUE_DEPTH - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						sweep_q <= sweep_q + IDX_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (take_ok) begin
							count_q <= count_q - CNT_W'(1);
						end
						if (flip_epoch) begin
							act_epoch_q <= !act_epoch_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (req_fire && (kind != KIND_TAKE)) begin
			success_q   <= ins_ok;
			taken_id_q  <= '0;
			taken_rem_q <= '0;
			taken_lvl_q <= '0;
		end else if (finish_fire) begin
			success_q   <= take_ok;
			taken_id_q  <= take_ok ? pick[IDX_LO-1:ID_LO] : '0;
			taken_rem_q <= take_ok ? pick[ID_LO-1:REM_LO] : '0;
			taken_lvl_q <= take_ok ? pick[1:0] : '0;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign success         = success_q;
	assign taken_id        = taken_id_q;
	assign taken_remaining = taken_rem_q;
	assign taken_level     = taken_lvl_q;

	// ------------------------------------------------------------------
	// Cell chain. Slot 0 holds the oldest entry. New entries land at the
	// fill count; on removal every cell at or above the picked slot copies
	// its upper neighbor, and the top cell sees an empty neighbor.
	// Candidates enter empty at slot 0 and move up one cell per cycle.
	// ------------------------------------------------------------------
	assign valid_vec[QUEUE_DEPTH] = 1'b0;
	assign id_vec[QUEUE_DEPTH]    = '0;
	assign rem_vec[QUEUE_DEPTH]   = '0;
	assign lvl_vec[QUEUE_DEPTH]   = '0;
	assign epoch_vec[QUEUE_DEPTH] = 1'b0;
	assign cand_a[0]              = '0;
	assign cand_b[0]              = '0;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		assign cell_ctrl[g].ins_here   = ins_fire && (count_q == CNT_W'(g));
		assign cell_ctrl[g].shift_here = rem_fire && (IDX_W'(g) >= pick_idx);
		assign cell_ctrl[g].policy     = policy_q;
		assign cell_ctrl[g].act_epoch  = act_epoch_q;
		assign cell_ctrl[g].ins_epoch  = (kind == KIND_INSERT) ? act_epoch_q : !act_epoch_q;
		assign valid_bits[g]           = valid_vec[g];

		rqs_cell #(
			.ID_BITS   (ID_BITS),
			.TIME_BITS (TIME_BITS),
			.IDX_BITS  (IDX_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl[g]),
			.my_idx     (IDX_W'(g)),
			.ins_id     (process_id),
			.ins_rem    (remaining_time),
			.ins_lvl    (priority_level),
			.nb_valid   (valid_vec[g+1]),
			.nb_id      (id_vec[g+1]),
			.nb_rem     (rem_vec[g+1]),
			.nb_lvl     (lvl_vec[g+1]),
			.nb_epoch   (epoch_vec[g+1]),
			.slot_valid (valid_vec[g]),
			.slot_id    (id_vec[g]),
			.slot_rem   (rem_vec[g]),
			.slot_lvl   (lvl_vec[g]),
			.slot_epoch (epoch_vec[g]),
			.cand_a_in  (cand_a[g]),
			.cand_b_in  (cand_b[g]),
			.cand_a_out (cand_a[g+1]),
			.cand_b_out (cand_b[g+1])
		);
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// The fill count always matches the number of occupied slots.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_bits) == count_q)
		else $error("fill count does not match occupied slots");

	// The fill count never passes the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fill count above queue depth");

	// A winning candidate always names an occupied slot.
	a_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rem_fire |-> valid_bits[pick_idx])
		else $error("picked slot is empty");

	// No item is taken in while a take is being worked on.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH || state_q == ST_FINISH) |-> req_stall)
		else $error("request accepted during a take");

endmodule

>>> dv/tb_ready_queue_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ready queue scheduler testbench
// Drives insert, expired insert, take and spare-kind items under every policy code,
// predicts each response with a behavioral queue model and compares the
// responses field by field, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_ready_queue_scheduler;
	import rqs_pkg::*;

	localparam int DEPTH  = 16;
	localparam int ID_W   = 10;
	localparam int TIME_W = 16;

	// A cycle count with no accepted item on either channel that no correct
	// run can reach: it allows for a take sweeping the whole chain, the
	// response stall and the request gap, and one more take for the drain
	// before a register write.
	localparam int STALL_LIMIT = 3000;

	// Codes that the package leaves unnamed. The spare policies behave as
	// FCFS and the spare request kind is answered with a plain failure.
	localparam logic [1:0] KIND_SPARE    = 2'd3;
	localparam logic [2:0] POL_SPARE_LO  = 3'd5;
	localparam logic [2:0] POL_SPARE_MID = 3'd6;
	localparam logic [2:0] POL_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic              success;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] rem;
		logic [1:0]        lvl;
	} decision_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] rem;
		logic [1:0]        lvl;
		logic              epoch;
	} entry_t;

	// One stimulus row: the policy it runs under, the request item, and a
	// typed-in response where one can be read off at a glance.
	typedef struct packed {
		logic [2:0]        mode;
		logic [1:0]        op;
		logic [ID_W-1:0]   pid;
		logic [TIME_W-1:0] rem;
		logic [1:0]        lvl;
		logic              fixed;
		decision_t         want;
	} step_t;

	localparam decision_t NO_DECISION = '{1'b0, 10'd0, 16'd0, 2'd0};
	localparam decision_t INSERTED    = '{1'b1, 10'd0, 16'd0, 2'd0};

	// Directed part. Rows with fixed set carry their response; the others
	// are checked against the queue model like the random items.
	localparam step_t DIRECTED [24] = '{
		// Empty queue, expired insert outside PRIO and the spare kind.
		'{POL_FCFS, KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b1, NO_DECISION},
		'{POL_FCFS, KIND_EXPIRED, 10'd3,    16'd3,    2'd3, 1'b1, NO_DECISION},
		'{POL_FCFS, KIND_SPARE,   10'd1023, 16'hFFFF, 2'd3, 1'b1, NO_DECISION},
		// Field extremes go in and come back out in arrival order.
		'{POL_FCFS, KIND_INSERT,  10'd1023, 16'hFFFF, 2'd3, 1'b1, INSERTED},
		'{POL_FCFS, KIND_INSERT,  10'd0,    16'd0,    2'd0, 1'b1, INSERTED},
		'{POL_FCFS, KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b1,
			'{1'b1, 10'd1023, 16'hFFFF, 2'd3}},
		'{POL_FCFS, KIND_TAKE,    10'd1,    16'd1,    2'd1, 1'b1,
			'{1'b1, 10'd0, 16'd0, 2'd0}},
		// LCFS takes the newest entry.
		'{POL_LCFS, KIND_INSERT,  10'd5,    16'd100,  2'd1, 1'b1, INSERTED},
		'{POL_LCFS, KIND_INSERT,  10'd6,    16'd50,   2'd2, 1'b1, INSERTED},
		'{POL_LCFS, KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b0, NO_DECISION},
		// SJF with a tie on the remaining time: the older entry wins.
		'{POL_SJF,  KIND_INSERT,  10'd7,    16'd100,  2'd0, 1'b1, INSERTED},
		'{POL_SJF,  KIND_INSERT,  10'd8,    16'd300,  2'd3, 1'b1, INSERTED},
		'{POL_SJF,  KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b0, NO_DECISION},
		'{POL_RR,   KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b0, NO_DECISION},
		// PRIO: level order among active entries, then the set swap, and a
		// swap on an empty queue.
		'{POL_PRIO, KIND_EXPIRED, 10'd9,    16'd10,   2'd3, 1'b1, INSERTED},
		'{POL_PRIO, KIND_INSERT,  10'd10,   16'd20,   2'd1, 1'b1, INSERTED},
		'{POL_PRIO, KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b0, NO_DECISION},
		'{POL_PRIO, KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b0, NO_DECISION},
		'{POL_PRIO, KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b0, NO_DECISION},
		'{POL_PRIO, KIND_TAKE,    10'd0,    16'd0,    2'd0, 1'b1, NO_DECISION},
		'{POL_PRIO, KIND_SPARE,   10'd0,    16'd0,    2'd0, 1'b1, NO_DECISION},
		// Spare policy codes fall back to FCFS.
		'{POL_SPARE_LO,  KIND_INSERT, 10'd11, 16'd1,  2'd2, 1'b1, INSERTED},
		'{POL_SPARE_HI,  KIND_TAKE,   10'd0,  16'd0,  2'd0, 1'b0, NO_DECISION},
		'{POL_SPARE_MID, KIND_TAKE,   10'd0,  16'd0,  2'd0, 1'b1, NO_DECISION}
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_write_en = 1'b0;
	logic [2:0]        cfg_write_data = POL_FCFS;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [1:0]        kind = KIND_INSERT;
	logic [ID_W-1:0]   process_id = '0;
	logic [TIME_W-1:0] remaining_time = '0;
	logic [1:0]        priority_level = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              success;
	logic [ID_W-1:0]   taken_id;
	logic [TIME_W-1:0] taken_remaining;
	logic [1:0]        taken_level;

	// Side band that travels with each request item: when set, the typed-in
	// response replaces the model's prediction for that item.
	logic      want_fixed = 1'b0;
	decision_t want_decision = NO_DECISION;

	// While calm is set neither side inserts gaps or stalls.
	logic calm = 1'b0;

	int        mismatches = 0;
	int        idle_cycles = 0;
	decision_t pending_decisions [$];

	// Queue model: entries in arrival order, oldest at index 0.
	entry_t     slots [DEPTH];
	int         fill = 0;
	logic       cur_epoch = 1'b0;
	logic [2:0] model_mode = POL_FCFS;

	ready_queue_scheduler #(
		.QUEUE_DEPTH(DEPTH),
		.ID_BITS(ID_W),
		.TIME_BITS(TIME_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.process_id(process_id),
		.remaining_time(remaining_time),
		.priority_level(priority_level),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.success(success),
		.taken_id(taken_id),
		.taken_remaining(taken_remaining),
		.taken_level(taken_level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one request item to the queue model and returns the response
	// the block must give for it.
	function automatic decision_t decide(logic [1:0] op, logic [ID_W-1:0] pid,
			logic [TIME_W-1:0] rem, logic [1:0] lvl);
		decision_t d;
		int pick;
		logic prio;
		logic any_active;
		d = NO_DECISION;
		pick = -1;
		prio = (model_mode == POL_PRIO);
		if (op == KIND_INSERT || op == KIND_EXPIRED) begin
			// Expired inserts only mean something under PRIO; a full queue
			// turns every insert away.
			if ((op == KIND_INSERT || prio) && fill < DEPTH) begin
				slots[fill] = '{pid, rem, lvl,
					(op == KIND_INSERT) ? cur_epoch : ~cur_epoch};
				fill++;
				d.success = 1'b1;
			end
			return d;
		end
		if (op != KIND_TAKE)
			return d;
		if (prio) begin
			// With no active entry left the sets swap first, even when the
			// queue is empty. Strict compare keeps the oldest within a level.
			any_active = 1'b0;
			for (int i = 0; i < fill; i++)
				if (slots[i].epoch == cur_epoch)
					any_active = 1'b1;
			if (!any_active)
				cur_epoch = ~cur_epoch;
			for (int i = 0; i < fill; i++)
				if (slots[i].epoch == cur_epoch &&
						(pick < 0 || slots[i].lvl > slots[pick].lvl))
					pick = i;
		end else if (fill > 0) begin
			case (model_mode)
				POL_LCFS: begin
					pick = fill - 1;
				end
				POL_SJF: begin
					pick = 0;
					for (int i = 1; i < fill; i++)
						if (slots[i].rem < slots[pick].rem)
							pick = i;
				end
				default: begin
					pick = 0;
				end
			endcase
		end
		if (pick < 0)
			return d;
		d = '{1'b1, slots[pick].id, slots[pick].rem, slots[pick].lvl};
		for (int i = pick; i + 1 < fill; i++)
			slots[i] = slots[i + 1];
		fill--;
		return d;
	endfunction

	task automatic report(string field, int unsigned want, int unsigned got);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", field, want, got, $time);
		mismatches++;
	endtask

	// Everything that changes the model happens here, at the edge that
	// accepts it, in a fixed order: register write, request, response.
	always @(posedge clk) begin
		decision_t d;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_write_en)
				model_mode = cfg_write_data;
			if (req_valid && !req_stall) begin
				d = decide(kind, process_id, remaining_time, priority_level);
				pending_decisions.insert(pending_decisions.size(),
					want_fixed ? want_decision : d);
				moved = 1'b1;
			end
			if (rsp_valid && !rsp_stall) begin
				moved = 1'b1;
				if (pending_decisions.size() == 0) begin
					report("unexpected response item", 0, 1);
				end else begin
					d = pending_decisions.pop_front();
					if (success !== d.success)
						report("success", d.success, success);
					if (taken_id !== d.id)
						report("taken_id", d.id, taken_id);
					if (taken_remaining !== d.rem)
						report("taken_remaining", d.rem, taken_remaining);
					if (taken_level !== d.lvl)
						report("taken_level", d.lvl, taken_level);
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// Response side. For each item a stall length is drawn; about half the
	// time it only counts down while a response is offered, so that stalls
	// land on the final step and not just during the search.
	int   stall_left = 0;
	logic stall_early = 1'b0;

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			stall_left = calm ? 0 : $urandom_range(0, 19);
			stall_early = 1'($urandom_range(0, 1));
		end
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			if (rsp_valid || stall_early)
				stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Presents one item after a random gap and returns at the edge that
	// accepts it. With no gap the next item follows on the same edge with
	// valid held high.
	task automatic send_item(step_t s);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid      <= 1'b1;
		kind           <= s.op;
		process_id     <= s.pid;
		remaining_time <= s.rem;
		priority_level <= s.lvl;
		want_fixed     <= s.fixed;
		want_decision  <= s.want;
		do
			@(posedge clk);
		while (!(req_valid && !req_stall));
	endtask

	// Holds the request channel idle until every response has arrived.
	// The queue is looked at on the falling edge, away from its updates.
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_decisions.size() != 0);
		@(posedge clk);
	endtask

	task automatic set_policy(logic [2:0] mode);
		drain();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= mode;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Random item. The insert share shapes the fill level: high shares run
	// the queue into its full state, low ones drain it to empty. Field
	// values lean toward extremes and small remaining times so that SJF
	// sees ties.
	function automatic step_t random_step(logic [2:0] mode, int insert_pct);
		step_t s;
		int roll;
		s = '0;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			s.op = KIND_SPARE;
		else if (roll < 3 + insert_pct)
			s.op = ((mode == POL_PRIO && $urandom_range(0, 2) == 0) ||
				$urandom_range(0, 19) == 0) ? KIND_EXPIRED : KIND_INSERT;
		else
			s.op = KIND_TAKE;
		s.pid = ID_W'($urandom);
		case ($urandom_range(0, 3))
			0: s.rem = TIME_W'($urandom_range(0, 7));
			1: s.rem = $urandom_range(0, 1) ? '1 : '0;
			default: s.rem = TIME_W'($urandom);
		endcase
		s.lvl = 2'($urandom);
		s.mode = mode;
		return s;
	endfunction

	// Watchdog: ends the run when nothing moves for too long.
	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int cur_mode;
		int insert_pct;
		logic [2:0] mode;
		cur_mode = -1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; the register is rewritten whenever the policy of a
		// row differs from the one in force, which includes the first row.
		foreach (DIRECTED[i]) begin
			if (int'(DIRECTED[i].mode) != cur_mode) begin
				set_policy(DIRECTED[i].mode);
				cur_mode = int'(DIRECTED[i].mode);
			end
			send_item(DIRECTED[i]);
		end

		// Random phases of 40 items. The first eight walk every policy code,
		// the rest draw one. Every fourth phase runs without gaps or stalls.
		for (int ph = 0; ph < 16; ph++) begin
			mode = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 7));
			case (ph % 3)
				0: insert_pct = 80;
				1: insert_pct = 35;
				default: insert_pct = 55;
			endcase
			set_policy(mode);
			calm <= (ph % 4 == 3);
			for (int n = 0; n < 40; n++) begin
				// Now and then the sender waits for every response.
				if ($urandom_range(0, 29) == 0)
					drain();
				send_item(random_step(mode, insert_pct));
			end
		end

		drain();
		repeat (DEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
